// ----- design/phidp_pkg.sv -----
package phidp_pkg;

   localparam int PHASE_ID_W   = 16;
   localparam int REUSE_W      = 12;
   localparam int MISS_TOTAL_W = 32;

   typedef struct packed {
      logic [PHASE_ID_W-1:0] phase_id;
      logic [REUSE_W-1:0]    reuse_count;
   } req_payload_type;

   typedef struct packed {
      logic [PHASE_ID_W-1:0]   predicted_id;
      logic                    mispredicted;
      logic [MISS_TOTAL_W-1:0] mispredict_total;
      logic                    clear_reuse;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_READ,
      ST_RESP
   } state_type;

endpackage

// ----- design/phidp_req_if.sv -----
interface phidp_req_if
   import phidp_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/phidp_rsp_if.sv -----
interface phidp_rsp_if
   import phidp_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/phase_id_history_predictor_unit.sv -----
// Phase-id history predictor.
// req_ch carries one item per phase interval: the phase id just seen and its
// reuse count. rsp_ch returns exactly one item per request: the predicted id
// of the next phase, the mispredict flag, the running mispredict total and
// the clear_reuse flag for the phase table. Both channels use valid/ready;
// an item moves on a rising edge with valid and ready high.
// Sequence: an item passes through accept, table write and history fold,
// table read and result load; the result load fills the output register
// and waits while that register holds a result not yet taken, and the next
// item can be accepted only after that load. The
// single port of the history table sets this sequence: the write for the previous
// prediction and the read for the new one use it in successive cycles, and
// the read data is registered. req_ch.ready is high only while no item is
// in progress.
// Reset (synchronous, active high) clears the control, history and window
// registers, then a pass writes zero into all HISTORY_LEN * 2**ceil(log2
// TABLE_SLOTS) table entries, one per cycle; no item is taken meanwhile.
// Stall: the result sits in an output register; a new item is accepted while
// it waits, and that item holds in its last step until rsp_ch.ready frees
// the register.
module phase_id_history_predictor_unit
   import phidp_pkg::*;
#(
   parameter int TABLE_SLOTS = 256,
   parameter int HISTORY_LEN = 12
) (
   input  logic             clock,
   input  logic             reset,
   phidp_req_if.sink        req_ch,
   phidp_rsp_if.source      rsp_ch
);

   localparam int ROW_W     = $clog2(HISTORY_LEN);
   localparam int SLOT_W    = $clog2(TABLE_SLOTS);
   localparam int FILL_W    = $clog2(HISTORY_LEN + 1);
   localparam int ADDR_W    = ROW_W + SLOT_W;
   localparam int MEM_DEPTH = HISTORY_LEN * (1 << SLOT_W);
   localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);

   state_type state_ff, state_in;

   logic [PHASE_ID_W-1:0]   hist_ff [HISTORY_LEN];
   logic [PHASE_ID_W-1:0]   hist_in [HISTORY_LEN];
   logic [PHASE_ID_W-1:0]   win_ff  [HISTORY_LEN];
   logic [PHASE_ID_W-1:0]   win_in  [HISTORY_LEN];
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [ROW_W-1:0]        last_row_ff, last_row_in;
   logic [PHASE_ID_W-1:0]   last_pred_ff, last_pred_in;
   logic [PHASE_ID_W-1:0]   last_id_ff, last_id_in;
   logic [MISS_TOTAL_W-1:0] miss_total_ff, miss_total_in;
   logic                    miss_ff, miss_in;
   logic [PHASE_ID_W-1:0]   id_ff, id_in;
   logic [REUSE_W-1:0]      reuse_ff, reuse_in;
   logic [PHASE_ID_W-1:0]   zero_pred_ff, zero_pred_in;
   logic [ADDR_W-1:0]       clear_idx_ff, clear_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_data_ff, rsp_data_in;

   logic [PHASE_ID_W-1:0]   hist_mem [MEM_DEPTH];
   logic [PHASE_ID_W-1:0]   rd_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_addr;
   logic [PHASE_ID_W-1:0]   mem_wdata;

   logic [SLOT_W-1:0]       slot;
   logic [PHASE_ID_W-1:0]   fold_word;
   logic [PHASE_ID_W-1:0]   pred;
   logic                    accept;
   logic                    rsp_free;

   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // one slot lookup serves both the write and the read of an item
   assign slot = hist_ff[last_row_ff][SLOT_W-1:0] & SLOT_MASK;

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      hist_in       = hist_ff;
      win_in        = win_ff;
      fill_in       = fill_ff;
      last_row_in   = last_row_ff;
      last_pred_in  = last_pred_ff;
      last_id_in    = last_id_ff;
      miss_total_in = miss_total_ff;
      miss_in       = miss_ff;
      id_in         = id_ff;
      reuse_in      = reuse_ff;
      zero_pred_in  = zero_pred_ff;
      clear_idx_in  = clear_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_addr      = {last_row_ff, slot};
      mem_wdata     = id_ff;
      pred          = id_ff;
      fold_word     = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            mem_addr     = clear_idx_ff;
            mem_wdata    = '0;
            clear_idx_in = clear_idx_ff + 1'b1;
            if (clear_idx_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               id_in    = req_ch.payload.phase_id;
               reuse_in = req_ch.payload.reuse_count;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // record the id where the previous prediction came from
            mem_we = 1'b1;

            // window push, oldest first
            if (fill_ff == FILL_W'(HISTORY_LEN)) begin
               for (int k = 0; k < HISTORY_LEN - 1; k++) begin
                  win_in[k] = win_ff[k+1];
               end
               win_in[HISTORY_LEN-1] = id_ff;
            end else begin
               for (int k = 0; k < HISTORY_LEN; k++) begin
                  if (FILL_W'(k) == fill_ff) begin
                     win_in[k] = id_ff;
                  end
               end
               fill_in = fill_ff + 1'b1;
            end

            miss_in       = (id_ff != last_pred_ff);
            miss_total_in = miss_total_ff + MISS_TOTAL_W'(miss_in);

            // fold the new window into the history registers
            for (int i = 1; i < HISTORY_LEN; i++) begin
               fold_word = (FILL_W'(i - 1) < fill_in) ? win_in[i-1] : '0;
               hist_in[HISTORY_LEN-i] = hist_ff[HISTORY_LEN-i] ^ fold_word ^ id_ff;
            end
            hist_in[0] = hist_ff[0] ^ id_ff;

            zero_pred_in = (fill_ff != '0) ? last_id_ff : id_ff;
            last_id_in   = id_ff;

            if (reuse_ff == '0 || reuse_ff > REUSE_W'(HISTORY_LEN - 1)) begin
               last_row_in = '0;
            end else begin
               last_row_in = reuse_ff[ROW_W-1:0];
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (reuse_ff == '0) begin
               pred = zero_pred_ff;
            end else if (rd_ff != '0) begin
               pred = rd_ff;
            end
            if (rsp_free) begin
               last_pred_in                 = pred;
               rsp_valid_in                 = 1'b1;
               rsp_data_in.predicted_id     = pred;
               rsp_data_in.mispredicted     = miss_ff;
               rsp_data_in.mispredict_total = miss_total_ff;
               rsp_data_in.clear_reuse      = (reuse_ff != '0);
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_LEN; k++) begin
            hist_ff[k] <= '0;
            win_ff[k]  <= '0;
         end
         fill_ff       <= '0;
         last_row_ff   <= '0;
         last_pred_ff  <= '0;
         last_id_ff    <= '0;
         miss_total_ff <= '0;
         clear_idx_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hist_ff       <= hist_in;
         win_ff        <= win_in;
         fill_ff       <= fill_in;
         last_row_ff   <= last_row_in;
         last_pred_ff  <= last_pred_in;
         last_id_ff    <= last_id_in;
         miss_total_ff <= miss_total_in;
         clear_idx_ff  <= clear_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      miss_ff      <= miss_in;
      id_ff        <= id_in;
      reuse_ff     <= reuse_in;
      zero_pred_ff <= zero_pred_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= hist_mem[mem_addr];
   end

`ifndef SYNTHESIS
   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_UPDATE)
      else $error("accepted item did not start an update");

   a_result_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result appeared outside the result step");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      last_row_ff <= ROW_W'(HISTORY_LEN - 1))
      else $error("history row out of range");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(HISTORY_LEN))
      else $error("window fill exceeds its length");

   a_total_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_UPDATE) |=> $stable(miss_total_ff))
      else $error("mispredict total changed outside an update");
`endif

endmodule
